[src/ura_pkg.sv]
// ----------------------------------------------------------------------------
// ura_pkg
// Shared constants, types and helpers for the radix-to-ASCII converter.
// ----------------------------------------------------------------------------
package ura_pkg;

  localparam int MAX_DIGITS = 32;
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int VAL_W      = 32;
  localparam int RAD_W      = 5;
  localparam int DIG_W      = 4;
  localparam int CHR_W      = 7;
  localparam int STEP_W     = $clog2(VAL_W);

  localparam logic [RAD_W-1:0] RADIX_MIN = RAD_W'(2);
  localparam logic [RAD_W-1:0] RADIX_MAX = RAD_W'(16);

  localparam logic [CHR_W-1:0] CHR_ZERO  = CHR_W'(8'h30);
  localparam logic [CHR_W-1:0] CHR_UPPER = CHR_W'(8'h41);
  localparam logic [CHR_W-1:0] CHR_LOWER = CHR_W'(8'h61);
  localparam logic [DIG_W-1:0] DIG_TEN   = DIG_W'(10);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } ura_state_t;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctrl_t;

  function automatic logic [CHR_W-1:0] digit_char(input logic [DIG_W-1:0] d,
                                                  input logic upper);
    logic [CHR_W-1:0] base;
    if (d < DIG_TEN) begin
      digit_char = CHR_ZERO + CHR_W'(d);
    end else begin
      base = upper ? CHR_UPPER : CHR_LOWER;
      digit_char = base + CHR_W'(d - DIG_TEN);
    end
  endfunction

endpackage

[src/ura_divider.sv]
// ----------------------------------------------------------------------------
// ura_divider
// Bit-serial restoring divider: one dividend bit per cycle, remainder < radix.
// ----------------------------------------------------------------------------
module ura_divider (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ura_pkg::div_ctrl_t        ctrl,
  input  logic [ura_pkg::VAL_W-1:0] dividend,
  input  logic [ura_pkg::RAD_W-1:0] divisor,
  output ura_pkg::div_stat_t        stat,
  output logic [ura_pkg::VAL_W-1:0] quotient,
  output logic [ura_pkg::DIG_W-1:0] remainder
);
  import ura_pkg::*;

  logic [VAL_W-1:0]  q_r, q_nxt;
  logic [RAD_W-1:0]  rem_r, rem_nxt;
  logic [RAD_W-1:0]  dvs_r;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [RAD_W-1:0]  trial;
  logic              fits;

  assign trial = {rem_r[RAD_W-2:0], q_r[VAL_W-1]};
  assign fits  = trial >= dvs_r;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (ctrl.start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt    = {q_r[VAL_W-2:0], fits};
      rem_nxt  = fits ? trial - dvs_r : trial;
      step_nxt = step_r + STEP_W'(1);
      if (step_r == STEP_W'(VAL_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (ctrl.start) begin
      dvs_r <= divisor;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r[DIG_W-1:0];

endmodule

[src/ura_digit_stack.sv]
// ----------------------------------------------------------------------------
// ura_digit_stack
// LIFO shift register of digits; push enters at the top, pop shifts up.
// ----------------------------------------------------------------------------
module ura_digit_stack (
  input  logic                      clk,
  input  ura_pkg::stk_ctrl_t        ctrl,
  input  logic [ura_pkg::DIG_W-1:0] push_digit,
  output logic [ura_pkg::DIG_W-1:0] top_digit
);
  import ura_pkg::*;

  logic [DIG_W-1:0] stk_r [MAX_DIGITS];

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      stk_r[0] <= push_digit;
      for (int i = 1; i < MAX_DIGITS; i++) begin
        stk_r[i] <= stk_r[i-1];
      end
    end else if (ctrl.pop) begin
      for (int i = 0; i < MAX_DIGITS - 1; i++) begin
        stk_r[i] <= stk_r[i+1];
      end
      stk_r[MAX_DIGITS-1] <= '0;
    end
  end

  assign top_digit = stk_r[0];

endmodule

[src/unsigned_radix_to_ascii.sv]
// ----------------------------------------------------------------------------
// unsigned_radix_to_ascii
// Converts a 32-bit unsigned value to ASCII digits in radix 2..16, MSB first.
// ----------------------------------------------------------------------------
// One request is taken at a time. Each digit is produced by a bit-serial
// divider that runs one full division per digit, so the time a number
// occupies the block grows with its significant digits and output
// characters. Digits are held in a LIFO shift register and leave one
// character per cycle, while the output is not stalled, through an output
// register, which may still hold the last character while the next request
// is accepted. Radix saturates to 2..16, padding is capped at MAX_DIGITS,
// and a zero value without padding gives a single '0'.
module unsigned_radix_to_ascii (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [31:0]               in_value,
  input  logic [4:0]                in_radix,
  input  logic                      in_upper_case,
  input  logic [5:0]                in_min_digits,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [6:0]                out_char_code,
  output logic                      out_last
);
  import ura_pkg::*;

  ura_state_t       state_r, state_nxt;
  logic [RAD_W-1:0] rad_r, rad_nxt;
  logic             upper_r, upper_nxt;
  logic [CNT_W-1:0] pad_r, pad_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [CHR_W-1:0] char_r, char_nxt;
  logic             last_r, last_nxt;
  logic             out_load;

  div_ctrl_t        div_ctrl;
  div_stat_t        div_stat;
  logic [VAL_W-1:0] div_dividend;
  logic [VAL_W-1:0] div_quo;
  logic [DIG_W-1:0] div_rem;
  stk_ctrl_t        stk_ctrl;
  logic [DIG_W-1:0] stk_top;

  logic [CNT_W-1:0] min_ext;
  logic [CNT_W-1:0] n_inc;
  logic             slot_free;

  function automatic logic [CNT_W-1:0] out_len(input logic [CNT_W-1:0] n,
                                               input logic [CNT_W-1:0] pad);
    logic [CNT_W-1:0] l;
    l = (n > pad) ? n : pad;
    if (l == '0) begin
      l = CNT_W'(1);
    end
    out_len = l;
  endfunction

  ura_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (div_ctrl),
    .dividend  (div_dividend),
    .divisor   (rad_nxt),
    .stat      (div_stat),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  ura_digit_stack u_stk (
    .clk        (clk),
    .ctrl       (stk_ctrl),
    .push_digit (div_rem),
    .top_digit  (stk_top)
  );

  assign min_ext      = CNT_W'(in_min_digits);
  assign n_inc        = n_r + CNT_W'(1);
  assign slot_free    = !out_valid_r || out_ready;
  assign div_dividend = (state_r == ST_IDLE) ? in_value : div_quo;

  always_comb begin
    state_nxt      = state_r;
    rad_nxt        = rad_r;
    upper_nxt      = upper_r;
    pad_nxt        = pad_r;
    n_nxt          = n_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r;
    char_nxt       = char_r;
    last_nxt       = last_r;
    out_load       = 1'b0;
    div_ctrl.start = 1'b0;
    stk_ctrl.push  = 1'b0;
    stk_ctrl.pop   = 1'b0;
    in_ready       = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_radix < RADIX_MIN) begin
            rad_nxt = RADIX_MIN;
          end else if (in_radix > RADIX_MAX) begin
            rad_nxt = RADIX_MAX;
          end else begin
            rad_nxt = in_radix;
          end
          upper_nxt = in_upper_case;
          pad_nxt   = (min_ext > CNT_W'(MAX_DIGITS)) ? CNT_W'(MAX_DIGITS) : min_ext;
          n_nxt     = '0;
          if (in_value == '0) begin
            cnt_nxt   = out_len('0, pad_nxt);
            state_nxt = ST_EMIT;
          end else begin
            div_ctrl.start = 1'b1;
            state_nxt      = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          stk_ctrl.push = 1'b1;
          n_nxt         = n_inc;
          if (div_quo == '0 || n_inc == CNT_W'(MAX_DIGITS)) begin
            cnt_nxt   = out_len(n_inc, pad_r);
            state_nxt = ST_EMIT;
          end else begin
            div_ctrl.start = 1'b1;
          end
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          if (cnt_r > n_r) begin
            char_nxt = digit_char('0, upper_r);
          end else begin
            char_nxt     = digit_char(stk_top, upper_r);
            stk_ctrl.pop = 1'b1;
          end
          last_nxt = (cnt_r == CNT_W'(1));
          cnt_nxt  = cnt_r - CNT_W'(1);
          if (cnt_r == CNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rad_r   <= rad_nxt;
    upper_r <= upper_nxt;
    pad_r   <= pad_nxt;
    n_r     <= n_nxt;
    cnt_r   <= cnt_nxt;
    if (out_load) begin
      char_r <= char_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = char_r;
  assign out_last      = last_r;

endmodule
